>>> src/tc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tc_pkg
// Shared widths, constants, command/status types and helpers for the
// transitive closure block.
// ----------------------------------------------------------------------------
package tc_pkg;

    // Fixed field widths
    localparam int ROW_W = 32;          // adjacency row width
    localparam int NUM_W = 5;           // row number field width
    localparam int CFG_W = 6;           // vertex count register width

    // Default storage depth and register reset value
    localparam int MAX_VERTICES_DEF = 32;
    localparam logic [CFG_W-1:0] VCOUNT_RST = 6'd32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_we;    // store the incoming row
        logic close_en;   // run one pivot pass
        logic emit_en;    // load the output register with a row
        logic emit_last;  // that row is the last of the matrix
    } tc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register can take a row this cycle
    } tc_sts_t;

    // Clamp a written vertex count to 1..limit
    function automatic logic [CFG_W-1:0] eff_count(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] limit);
        logic [CFG_W-1:0] r;
        r = v;
        if (r == '0)
            r = 6'd1;
        if (r > limit)
            r = limit;
        return r;
    endfunction

endpackage

>>> src/tc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tc_datapath
// Row storage, parallel pivot update and the registered output item.
// ----------------------------------------------------------------------------
module tc_datapath #(
    parameter int MAX_VERTICES = tc_pkg::MAX_VERTICES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tc_pkg::tc_cmd_t             cmd,
    output tc_pkg::tc_sts_t             sts,
    input  logic [tc_pkg::CFG_W-1:0]    vcount,
    input  logic [$clog2((MAX_VERTICES < tc_pkg::ROW_W) ? MAX_VERTICES
                                                         : tc_pkg::ROW_W)-1:0] load_idx,
    input  logic [$clog2((MAX_VERTICES < tc_pkg::ROW_W) ? MAX_VERTICES
                                                         : tc_pkg::ROW_W)-1:0] sel_idx,
    input  logic [tc_pkg::ROW_W-1:0]    row_in,
    input  logic                        m_axis_tready,
    output logic                        m_axis_tvalid,
    output logic [39:0]                 m_axis_tdata,
    output logic                        m_axis_tlast
);

    localparam int ROW_LIMIT = (MAX_VERTICES < tc_pkg::ROW_W) ? MAX_VERTICES : tc_pkg::ROW_W;

    logic [tc_pkg::ROW_W-1:0] rows_reg [ROW_LIMIT];
    logic [tc_pkg::ROW_W-1:0] col_mask;
    logic [tc_pkg::ROW_W-1:0] sel_row;
    logic [tc_pkg::NUM_W-1:0] sel_bit;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [tc_pkg::ROW_W-1:0] out_row_reg;
    logic [tc_pkg::NUM_W-1:0] out_num_reg;
    logic                     out_last_reg;

    // Column mask for the vertices in use
    assign col_mask = ~({tc_pkg::ROW_W{1'b1}} << vcount);

    // Shared row read: pivot row while closing, emitted row while emitting
    assign sel_row = rows_reg[sel_idx];
    assign sel_bit = tc_pkg::NUM_W'(sel_idx);

    // Load rows and run pivot passes over all rows at once
    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
        begin
            rows_reg[load_idx] <= row_in & col_mask;
        end
        else if (cmd.close_en)
        begin
            for (int i = 0; i < ROW_LIMIT; i++)
            begin
                if (rows_reg[i][sel_bit])
                    rows_reg[i] <= rows_reg[i] | sel_row;
            end
        end
    end

    // Output register handshake
    assign sts.out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_en)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Capture the emitted row
    always_ff @(posedge clk)
    begin
        if (cmd.emit_en)
        begin
            out_row_reg  <= sel_row;
            out_num_reg  <= sel_bit;
            out_last_reg <= cmd.emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_num_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> src/tc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tc_ctrl
// Sequencer for load, pivot and emit phases; holds the vertex count.
// ----------------------------------------------------------------------------
module tc_ctrl #(
    parameter int MAX_VERTICES = tc_pkg::MAX_VERTICES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tc_pkg::CFG_W-1:0]    cfg_data,
    output tc_pkg::tc_cmd_t             cmd,
    input  tc_pkg::tc_sts_t             sts,
    output logic [tc_pkg::CFG_W-1:0]    vcount,
    output logic [$clog2((MAX_VERTICES < tc_pkg::ROW_W) ? MAX_VERTICES
                                                         : tc_pkg::ROW_W)-1:0] load_idx,
    output logic [$clog2((MAX_VERTICES < tc_pkg::ROW_W) ? MAX_VERTICES
                                                         : tc_pkg::ROW_W)-1:0] sel_idx
);

    localparam int ROW_LIMIT = (MAX_VERTICES < tc_pkg::ROW_W) ? MAX_VERTICES : tc_pkg::ROW_W;
    localparam int IDX_W     = $clog2(ROW_LIMIT);
    localparam logic [tc_pkg::CFG_W-1:0] LIMIT = tc_pkg::CFG_W'(ROW_LIMIT);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_CLOSE = 3'b010,
        ST_EMIT  = 3'b100
    } tc_state_t;

    tc_state_t                state_reg, state_next;
    logic [tc_pkg::CFG_W-1:0] n_reg, n_next;
    logic [tc_pkg::CFG_W-1:0] load_cnt_reg, load_cnt_next;
    logic [tc_pkg::CFG_W-1:0] idx_reg, idx_next;
    logic                     in_acc;
    logic                     cfg_acc;
    logic                     idx_at_end;

    // Hold off input items while a count write is offered
    assign s_axis_tready = (state_reg == ST_LOAD) && !cfg_valid;
    assign cfg_ready     = (state_reg == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_acc       = cfg_valid && cfg_ready;
    assign idx_at_end    = (tc_pkg::CFG_W'(idx_reg + 6'd1) == n_reg);

    // Commands to the datapath
    always_comb
    begin
        cmd           = '0;
        cmd.load_we   = in_acc;
        cmd.close_en  = (state_reg == ST_CLOSE);
        cmd.emit_en   = (state_reg == ST_EMIT) && sts.out_free;
        cmd.emit_last = idx_at_end;
    end

    assign vcount   = n_reg;
    assign load_idx = load_cnt_reg[IDX_W-1:0];
    assign sel_idx  = idx_reg[IDX_W-1:0];

    // Next state and counters
    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        load_cnt_next = load_cnt_reg;
        idx_next      = idx_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (cfg_acc)
                begin
                    n_next        = tc_pkg::eff_count(cfg_data, LIMIT);
                    load_cnt_next = '0;
                end
                else if (in_acc)
                begin
                    if (tc_pkg::CFG_W'(load_cnt_reg + 6'd1) == n_reg)
                    begin
                        load_cnt_next = '0;
                        idx_next      = '0;
                        state_next    = ST_CLOSE;
                    end
                    else
                    begin
                        load_cnt_next = tc_pkg::CFG_W'(load_cnt_reg + 6'd1);
                    end
                end
            end
            ST_CLOSE:
            begin
                if (idx_at_end)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = tc_pkg::CFG_W'(idx_reg + 6'd1);
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (idx_at_end)
                    begin
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next = tc_pkg::CFG_W'(idx_reg + 6'd1);
                    end
                end
            end
            default:
            begin
                state_next    = ST_LOAD;
                load_cnt_next = '0;
                idx_next      = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            n_reg        <= tc_pkg::eff_count(tc_pkg::VCOUNT_RST, LIMIT);
            load_cnt_reg <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            load_cnt_reg <= load_cnt_next;
            idx_reg      <= idx_next;
        end
    end

    // Load counter never reaches the vertex count
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_cnt_reg < n_reg)
        else $error("load counter out of range");

    // Pivot and emit index stay inside the matrix
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (idx_reg < n_reg))
        else $error("row index out of range");

    // Last pivot pass hands over to emitting from row 0
    a_close_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE && idx_at_end) |=> (state_reg == ST_EMIT && idx_reg == '0))
        else $error("closing did not end in emitting");

    // Emit index holds while the output register is busy
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !sts.out_free) |=> (state_reg == ST_EMIT && $stable(idx_reg)))
        else $error("emit index moved under back-pressure");

endmodule

>>> src/transitive_closure.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transitive_closure
// Warshall transitive closure of a boolean adjacency matrix, streamed in and
// out one row per item.
// ----------------------------------------------------------------------------
// Send N rows (N = vertex count, 1..min(MAX_VERTICES, 32)), one per item, one
// per cycle; column bits at or above N are cleared on load. After the last
// row the block runs N pivot passes, one per cycle, each updating every row
// at once, then emits N closed rows from an output register, row number in
// tdata and tlast on the final row. Input is not taken during the pivot and
// emit phases nor while a vertex count write is offered, and the next matrix
// may start loading while the last row still waits at the output. The user
// must write the vertex count only between matrices; the block itself does
// not enforce this, and a write restarts loading at row 0.
// ----------------------------------------------------------------------------
module transitive_closure #(
    parameter int MAX_VERTICES = tc_pkg::MAX_VERTICES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // Input items: tdata = row_bits[31:0]
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,
    // Result items: tdata = closure_row[31:0], row_number[36:32], zero pad
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [39:0]              m_axis_tdata,
    output logic                     m_axis_tlast,
    // Vertex count register write: cfg_data = vertex_count[5:0]
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [tc_pkg::CFG_W-1:0] cfg_data
);

    localparam int ROW_LIMIT = (MAX_VERTICES < tc_pkg::ROW_W) ? MAX_VERTICES : tc_pkg::ROW_W;
    localparam int IDX_W     = $clog2(ROW_LIMIT);

    tc_pkg::tc_cmd_t          cmd;
    tc_pkg::tc_sts_t          sts;
    logic [tc_pkg::CFG_W-1:0] vcount;
    logic [IDX_W-1:0]         load_idx;
    logic [IDX_W-1:0]         sel_idx;

    // Phase sequencer
    tc_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .vcount        (vcount),
        .load_idx      (load_idx),
        .sel_idx       (sel_idx)
    );

    // Row storage and output register
    tc_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .vcount        (vcount),
        .load_idx      (load_idx),
        .sel_idx       (sel_idx),
        .row_in        (s_axis_tdata),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
